/* rtl/owbm_pkg.sv */
// Shared types and constants for the single-wire bus master.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package owbm_pkg;

  localparam int unsigned ID_BITS_DEFAULT = 64;
  localparam int unsigned CFG_REGS        = 8;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_W           = 12;
  localparam int unsigned BC_W            = 7;
  localparam int unsigned READ_W          = 64;

  localparam logic [CFG_W-1:0] READ_RECOVERY = 12'd60;
  localparam logic [7:0]       READ_ROM_CMD  = 8'h33;
  localparam logic [7:0]       CLOSING_BYTE  = 8'h00;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_RST_LOW   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RST_REL   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WR1_LOW   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WR1_REL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WR0_LOW   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_WR0_REL   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_RD_LOW    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_RD_SAMPLE = 3'd7;

  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef cfg_word_t [CFG_REGS-1:0] cfg_t;

  localparam cfg_t CFG_RESET = {12'd5, 12'd5, 12'd30, 12'd90,
                                12'd60, 12'd7, 12'd1090, 12'd500};

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_RESET      = 3'd1,
    CMD_WRITE_BIT  = 3'd2,
    CMD_READ_BIT   = 3'd3,
    CMD_WRITE_BYTE = 3'd4,
    CMD_READ_BYTE  = 3'd5,
    CMD_READ_ID    = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LOW = 4'd1,
    PH_RST_REL = 4'd2,
    PH_WR_LOW  = 4'd3,
    PH_WR_REL  = 4'd4,
    PH_RD_LOW  = 4'd5,
    PH_RD_WAIT = 4'd6,
    PH_RD_REC  = 4'd7
  } phase_e;

  typedef struct packed {
    logic              rejected;
    logic [READ_W-1:0] read_value;
    logic              done_res;
    logic              busy_res;
    logic              drive_low;
  } res_t;

endpackage

`default_nettype wire

/* rtl/owbm_cfg_regs.sv */
// Timing configuration registers of the single-wire bus master.
// Depends on owbm_pkg for the register count, widths and reset values.
`default_nettype none

module owbm_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [owbm_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [owbm_pkg::CFG_W-1:0]       cfg_data_i,
  output owbm_pkg::cfg_t                        cfg_o
);

  owbm_pkg::cfg_t regs_q, regs_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    regs_d = regs_q;
    if (cfg_valid_i) begin
      regs_d[cfg_addr_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= owbm_pkg::CFG_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign cfg_o = regs_q;

endmodule

`default_nettype wire

/* rtl/owbm_engine.sv */
// Per-tick sequencer of the single-wire bus master: command state, slot timer,
// bit counter and shift registers. Depends on owbm_pkg.
`default_nettype none

module owbm_engine #(
  parameter int unsigned ID_BITS = owbm_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_en_i,
  input  wire logic [2:0]          action_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                line_level_i,
  input  wire owbm_pkg::cfg_t      cfg_i,
  output owbm_pkg::res_t           res_o
);

  localparam int unsigned BC_W = owbm_pkg::BC_W;
  localparam int unsigned TW   = owbm_pkg::CFG_W;
  localparam logic [BC_W-1:0] BC_CLOSE    = BC_W'(8 + ID_BITS);
  localparam logic [BC_W-1:0] BC_ID_TOTAL = BC_W'(16 + ID_BITS);

  typedef struct packed {
    owbm_pkg::phase_e ph;
    logic [TW-1:0]    tmr;
    logic [7:0]       ws;
  } slot_t;

  owbm_pkg::phase_e            phase_q, phase_d, phase_act;
  owbm_pkg::cmd_e              cmd_q, cmd_d;
  logic [TW-1:0]               timer_q, timer_d;
  logic [BC_W-1:0]             bc_q, bc_d;
  logic [7:0]                  ws_q, ws_d;
  logic [owbm_pkg::READ_W-1:0] rs_q, rs_d;
  logic                        fin, rej;

  function automatic logic [TW-1:0] dur(input logic [TW-1:0] v);
    return (v == '0) ? TW'(1) : v;
  endfunction

  function automatic logic [BC_W-1:0] slot_total(input owbm_pkg::cmd_e c);
    logic [BC_W-1:0] n;
    case (c)
      owbm_pkg::CMD_WRITE_BIT, owbm_pkg::CMD_READ_BIT:   n = BC_W'(1);
      owbm_pkg::CMD_WRITE_BYTE, owbm_pkg::CMD_READ_BYTE: n = BC_W'(8);
      owbm_pkg::CMD_READ_ID:                             n = BC_ID_TOTAL;
      default:                                           n = '0;
    endcase
    return n;
  endfunction

  function automatic logic slot_is_write(input owbm_pkg::cmd_e c,
                                         input logic [BC_W-1:0] b);
    return (c == owbm_pkg::CMD_WRITE_BIT) || (c == owbm_pkg::CMD_WRITE_BYTE) ||
           ((c == owbm_pkg::CMD_READ_ID) && ((b < BC_W'(8)) || (b >= BC_CLOSE)));
  endfunction

  function automatic logic write_bit_now(input owbm_pkg::cmd_e c,
                                         input logic [BC_W-1:0] b,
                                         input logic [7:0] w);
    logic [BC_W-1:0] idx;
    idx = b;
    if ((c == owbm_pkg::CMD_READ_ID) && (b >= BC_CLOSE)) begin
      idx = b - BC_CLOSE;
    end
    return w[idx[2:0]];
  endfunction

  // open the next bit slot: write slots pick their low time from the bit value
  function automatic slot_t begin_slot(input owbm_pkg::cmd_e c,
                                       input logic [BC_W-1:0] b,
                                       input logic [7:0] w,
                                       input owbm_pkg::cfg_t cf);
    slot_t s;
    s.ws = w;
    if ((c == owbm_pkg::CMD_READ_ID) && (b == BC_CLOSE)) begin
      s.ws = owbm_pkg::CLOSING_BYTE;
    end
    if (slot_is_write(c, b)) begin
      s.ph  = owbm_pkg::PH_WR_LOW;
      s.tmr = write_bit_now(c, b, s.ws) ? dur(cf[owbm_pkg::CFG_WR1_LOW])
                                        : dur(cf[owbm_pkg::CFG_WR0_LOW]);
    end else begin
      s.ph  = owbm_pkg::PH_RD_LOW;
      s.tmr = dur(cf[owbm_pkg::CFG_RD_LOW]);
    end
    return s;
  endfunction

  // next state
  always_comb begin
    slot_t           sl;
    logic [BC_W-1:0] idx;
    phase_d = phase_q;
    cmd_d   = cmd_q;
    timer_d = timer_q;
    bc_d    = bc_q;
    ws_d    = ws_q;
    rs_d    = rs_q;
    fin     = 1'b0;
    rej     = 1'b0;
    sl      = '0;
    idx     = '0;

    if ((action_i >= owbm_pkg::CMD_RESET) && (action_i <= owbm_pkg::CMD_READ_ID)) begin
      if (phase_q == owbm_pkg::PH_IDLE) begin
        cmd_d = owbm_pkg::cmd_e'(action_i);
        bc_d  = '0;
        rs_d  = '0;
        ws_d  = (cmd_d == owbm_pkg::CMD_READ_ID) ? owbm_pkg::READ_ROM_CMD : data_byte_i;
        if ((cmd_d == owbm_pkg::CMD_RESET) || (cmd_d == owbm_pkg::CMD_READ_ID)) begin
          phase_d = owbm_pkg::PH_RST_LOW;
          timer_d = dur(cfg_i[owbm_pkg::CFG_RST_LOW]);
        end else begin
          sl      = begin_slot(cmd_d, bc_d, ws_d, cfg_i);
          phase_d = sl.ph;
          timer_d = sl.tmr;
          ws_d    = sl.ws;
        end
      end else begin
        rej = 1'b1;
      end
    end

    phase_act = phase_d;

    if (phase_act != owbm_pkg::PH_IDLE) begin
      // sample once, on the first recovery tick
      if ((phase_act == owbm_pkg::PH_RD_REC) && (timer_d == owbm_pkg::READ_RECOVERY) &&
          line_level_i) begin
        idx = (cmd_d == owbm_pkg::CMD_READ_ID) ? bc_d - BC_W'(8) : bc_d;
        rs_d[idx[5:0]] = 1'b1;
      end
      if (timer_d != '0) begin
        timer_d = timer_d - TW'(1);
      end
      if (timer_d == '0) begin
        case (phase_act)
          owbm_pkg::PH_RST_LOW: begin
            phase_d = owbm_pkg::PH_RST_REL;
            timer_d = dur(cfg_i[owbm_pkg::CFG_RST_REL]);
          end
          owbm_pkg::PH_WR_LOW: begin
            phase_d = owbm_pkg::PH_WR_REL;
            timer_d = write_bit_now(cmd_d, bc_d, ws_d) ? dur(cfg_i[owbm_pkg::CFG_WR1_REL])
                                                       : dur(cfg_i[owbm_pkg::CFG_WR0_REL]);
          end
          owbm_pkg::PH_RD_LOW: begin
            phase_d = owbm_pkg::PH_RD_WAIT;
            timer_d = dur(cfg_i[owbm_pkg::CFG_RD_SAMPLE]);
          end
          owbm_pkg::PH_RD_WAIT: begin
            phase_d = owbm_pkg::PH_RD_REC;
            timer_d = owbm_pkg::READ_RECOVERY;
          end
          owbm_pkg::PH_RST_REL, owbm_pkg::PH_WR_REL, owbm_pkg::PH_RD_REC: begin
            if (phase_act != owbm_pkg::PH_RST_REL) begin
              bc_d = bc_d + BC_W'(1);
            end
            if (bc_d < slot_total(cmd_d)) begin
              sl      = begin_slot(cmd_d, bc_d, ws_d, cfg_i);
              phase_d = sl.ph;
              timer_d = sl.tmr;
              ws_d    = sl.ws;
            end else begin
              phase_d = owbm_pkg::PH_IDLE;
              fin     = 1'b1;
            end
          end
          default: phase_d = owbm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    res_o.drive_low  = (phase_act == owbm_pkg::PH_RST_LOW) ||
                       (phase_act == owbm_pkg::PH_WR_LOW) ||
                       (phase_act == owbm_pkg::PH_RD_LOW);
    res_o.busy_res   = (phase_act != owbm_pkg::PH_IDLE);
    res_o.done_res   = fin;
    res_o.read_value = rs_d;
    res_o.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= owbm_pkg::PH_IDLE;
      cmd_q   <= owbm_pkg::CMD_TICK;
      timer_q <= '0;
      bc_q    <= '0;
      ws_q    <= '0;
      rs_q    <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      timer_q <= timer_d;
      bc_q    <= bc_d;
      ws_q    <= ws_d;
      rs_q    <= rs_d;
    end
  end

  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.done_res |-> res_o.busy_res)
    else $error("done without busy");

  a_reject_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.rejected |-> phase_q != owbm_pkg::PH_IDLE)
    else $error("command rejected while idle");

  a_timer_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && phase_d != owbm_pkg::PH_IDLE |=> timer_q != '0)
    else $error("active phase with empty timer");

  a_bc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BC_ID_TOTAL)
    else $error("bit counter past last slot");

endmodule

`default_nettype wire

/* rtl/one_wire_bus_master.sv */
// Top level of the single-wire bus master: stream ports, input and result registers.
// Depends on owbm_pkg, owbm_cfg_regs and owbm_engine.
`default_nettype none

// Each input transfer is one microsecond tick of bus time and yields exactly one
// result transfer. A new tick is taken every clock cycle while the result side
// does not stall; its result passes through the input register, one step of the
// slot sequencer, then the result register. Backpressure on the result side
// stalls the input side once both registers are full. Commands start only when
// idle; one arriving while a command runs is flagged as rejected.
// The user writes timing registers through the cfg port only while no tick is in
// flight; the block itself does not enforce this.
module one_wire_bus_master #(
  parameter int unsigned ID_BITS = owbm_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [2:0] action, [10:3] data_byte, [11] line_level, [15:12] zero
  input  wire logic [15:0]                     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [66:3] read_value, [67] rejected,
  // [71:68] zero
  output logic [71:0]                          m_axis_tdata,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [owbm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [owbm_pkg::CFG_W-1:0]      cfg_data_i
);

  owbm_pkg::cfg_t cfg;
  owbm_pkg::res_t res;

  logic        in_valid_q, in_valid_d;
  logic [11:0] in_data_q;
  logic        out_valid_q, out_valid_d;
  owbm_pkg::res_t out_res_q;
  logic        step_en, in_accept;

  assign step_en       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step_en) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: hold unless a transfer moves them
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= s_axis_tdata[11:0];
    end
    if (step_en) begin
      out_res_q <= res;
    end
  end

  owbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  owbm_engine #(
    .ID_BITS (ID_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (step_en),
    .action_i     (in_data_q[2:0]),
    .data_byte_i  (in_data_q[10:3]),
    .line_level_i (in_data_q[11]),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.rejected, out_res_q.read_value,
                          out_res_q.done_res, out_res_q.busy_res, out_res_q.drive_low};

endmodule

`default_nettype wire

/* verif/owbm_checker.sv */
`timescale 1ns / 1ps
// Result checker for one_wire_bus_master: predicts each tick's result and compares it.
// Depends on owbm_pkg; watches the tick, result and timing register channels only.
module owbm_checker #(
  parameter int unsigned ID_BITS = owbm_pkg::ID_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_valid_i,
  input  logic                            tick_ready_i,
  input  logic [15:0]                     tick_data_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [71:0]                     res_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [owbm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [owbm_pkg::CFG_W-1:0]      cfg_data_i,
  output int unsigned                     pending_o,
  output logic                            busy_o,
  output int unsigned                     fails_o,
  output int unsigned                     checked_o
);
  import owbm_pkg::*;

  // bus master state as the testbench sees it
  cfg_t              timing_q;
  phase_e            slot_phase;
  cmd_e              active_cmd;
  logic [CFG_W-1:0]  phase_left;
  logic [BC_W-1:0]   slot_idx;
  logic [7:0]        tx_byte;
  logic [READ_W-1:0] rx_bits;
  logic              cmd_finished;

  res_t        tick_results_q[$];
  res_t        seen, owed, fresh;
  int unsigned fail_cnt;
  int unsigned checked_cnt;

  function automatic logic [CFG_W-1:0] ticks_of(input logic [CFG_ADDR_W-1:0] idx);
    return (timing_q[idx] == '0) ? CFG_W'(1) : timing_q[idx];
  endfunction

  function automatic int unsigned slots_in_cmd();
    case (active_cmd)
      CMD_WRITE_BIT, CMD_READ_BIT:   return 1;
      CMD_WRITE_BYTE, CMD_READ_BYTE: return 8;
      CMD_READ_ID:                   return 16 + ID_BITS;
      default:                       return 0;
    endcase
  endfunction

  // ROM id: 8 command bits out, ID_BITS in, then the closing byte out
  function automatic logic slot_writes();
    if (active_cmd == CMD_WRITE_BIT || active_cmd == CMD_WRITE_BYTE) return 1'b1;
    if (active_cmd == CMD_READ_ID) return (slot_idx < 8) || (slot_idx >= 8 + ID_BITS);
    return 1'b0;
  endfunction

  function automatic logic tx_bit();
    logic [BC_W-1:0] pos;
    pos = slot_idx;
    if (active_cmd == CMD_READ_ID && slot_idx >= 8 + ID_BITS)
      pos = slot_idx - BC_W'(8 + ID_BITS);
    return tx_byte[pos[2:0]];
  endfunction

  function automatic void open_slot();
    if (active_cmd == CMD_READ_ID && slot_idx == 8 + ID_BITS) tx_byte = CLOSING_BYTE;
    if (slot_writes()) begin
      slot_phase = PH_WR_LOW;
      phase_left = tx_bit() ? ticks_of(CFG_WR1_LOW) : ticks_of(CFG_WR0_LOW);
    end else begin
      slot_phase = PH_RD_LOW;
      phase_left = ticks_of(CFG_RD_LOW);
    end
  endfunction

  function automatic void next_slot_or_end();
    if (slot_idx < slots_in_cmd()) begin
      open_slot();
    end else begin
      slot_phase   = PH_IDLE;
      cmd_finished = 1'b1;
    end
  endfunction

  function automatic void leave_phase();
    case (slot_phase)
      PH_RST_LOW: begin
        slot_phase = PH_RST_REL;
        phase_left = ticks_of(CFG_RST_REL);
      end
      PH_RST_REL: next_slot_or_end();
      PH_WR_LOW: begin
        slot_phase = PH_WR_REL;
        phase_left = tx_bit() ? ticks_of(CFG_WR1_REL) : ticks_of(CFG_WR0_REL);
      end
      PH_RD_LOW: begin
        slot_phase = PH_RD_WAIT;
        phase_left = ticks_of(CFG_RD_SAMPLE);
      end
      PH_RD_WAIT: begin
        slot_phase = PH_RD_REC;
        phase_left = READ_RECOVERY;
      end
      PH_WR_REL, PH_RD_REC: begin
        slot_idx = slot_idx + 1'b1;
        next_slot_or_end();
      end
      default: slot_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void start_cmd(input logic [2:0] act, input logic [7:0] data);
    active_cmd = cmd_e'(act);
    slot_idx   = '0;
    rx_bits    = '0;
    tx_byte    = (active_cmd == CMD_READ_ID) ? READ_ROM_CMD : data;
    if (active_cmd == CMD_RESET || active_cmd == CMD_READ_ID) begin
      slot_phase = PH_RST_LOW;
      phase_left = ticks_of(CFG_RST_LOW);
    end else begin
      open_slot();
    end
  endfunction

  // one microsecond of bus time
  function automatic res_t bus_tick(input logic [2:0] act, input logic [7:0] data,
                                    input logic line);
    res_t            r;
    logic [BC_W-1:0] rx_pos;
    r = '0;
    cmd_finished = 1'b0;
    if (act >= CMD_RESET && act <= CMD_READ_ID) begin
      if (slot_phase == PH_IDLE) start_cmd(act, data);
      else r.rejected = 1'b1;
    end
    if (slot_phase != PH_IDLE) begin
      r.busy_res  = 1'b1;
      r.drive_low = (slot_phase == PH_RST_LOW) || (slot_phase == PH_WR_LOW) ||
                    (slot_phase == PH_RD_LOW);
      // sample once, on the first recovery tick
      if (slot_phase == PH_RD_REC && phase_left == READ_RECOVERY && line) begin
        rx_pos = (active_cmd == CMD_READ_ID) ? slot_idx - 7'd8 : slot_idx;
        rx_bits[rx_pos[5:0]] = 1'b1;
      end
      if (phase_left != 0) phase_left = phase_left - 1'b1;
      if (phase_left == 0) leave_phase();
    end
    r.done_res   = cmd_finished;
    r.read_value = rx_bits;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q     = CFG_RESET;
      slot_phase   = PH_IDLE;
      active_cmd   = CMD_TICK;
      phase_left   = '0;
      slot_idx     = '0;
      tx_byte      = '0;
      rx_bits      = '0;
      cmd_finished = 1'b0;
      tick_results_q.delete();
      fail_cnt     = 0;
      checked_cnt  = 0;
      pending_o   <= 0;
      busy_o      <= 1'b0;
      fails_o     <= 0;
      checked_o   <= 0;
    end else begin
      // retire before predicting, so a result never meets its own tick's prediction
      if (res_valid_i && res_ready_i) begin
        seen = res_t'(res_data_i[67:0]);
        if (tick_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, seen);
          fail_cnt++;
        end else begin
          owed = tick_results_q.pop_front();
          check_field("drive_low", owed.drive_low, seen.drive_low);
          check_field("busy_res", owed.busy_res, seen.busy_res);
          check_field("done_res", owed.done_res, seen.done_res);
          check_field("read_value", owed.read_value, seen.read_value);
          check_field("rejected", owed.rejected, seen.rejected);
          checked_cnt++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) timing_q[cfg_addr_i] = cfg_data_i;
      if (tick_valid_i && tick_ready_i) begin
        fresh = bus_tick(tick_data_i[2:0], tick_data_i[10:3], tick_data_i[11]);
        tick_results_q.push_back(fresh);
      end
      pending_o <= tick_results_q.size();
      busy_o    <= (slot_phase != PH_IDLE);
      fails_o   <= fail_cnt;
      checked_o <= checked_cnt;
    end
  end

endmodule

/* verif/one_wire_bus_master_tb.sv */
`timescale 1ns / 1ps
// Top of the single-wire bus master testbench: clock, reset, timing loads and tick stimulus.
// Depends on owbm_pkg, one_wire_bus_master and owbm_checker, which owns all result checks.
module one_wire_bus_master_tb;
  import owbm_pkg::*;

  localparam logic [2:0]  ACT_SPARE     = 3'd7;  // no command behind it, a plain tick
  localparam logic [1:0]  LINE_LOW      = 2'd0;
  localparam logic [1:0]  LINE_HIGH     = 2'd1;
  localparam logic [1:0]  LINE_RAND     = 2'd2;
  localparam int unsigned RAND_TICKS    = 300;
  localparam int unsigned RAND_SETS     = 2;
  // reset, command byte and the first few read slots at one-tick timing
  localparam int unsigned ID_HEAD_TICKS = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  int unsigned pending, fails, checked;
  logic        model_busy;
  bit          quiet = 1'b0;
  cfg_t        timing = CFG_RESET;
  int unsigned ticks_sent, cmds_sent, settings_used, cycles;
  int unsigned sink_stall, sink_gap;

  always #4 clk_i = ~clk_i;

  one_wire_bus_master DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  owbm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .busy_o       (model_busy),
    .fails_o      (fails),
    .checked_o    (checked)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 70) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic int unsigned phase_ticks(input logic [CFG_ADDR_W-1:0] idx);
    return (timing[idx] == '0) ? 1 : timing[idx];
  endfunction

  // upper bound on a command's length in ticks under the loaded timing
  function automatic int unsigned cmd_len(input logic [2:0] act);
    int unsigned wr1, wr0, wr, rd, rst;
    wr1 = phase_ticks(CFG_WR1_LOW) + phase_ticks(CFG_WR1_REL);
    wr0 = phase_ticks(CFG_WR0_LOW) + phase_ticks(CFG_WR0_REL);
    wr  = (wr1 > wr0) ? wr1 : wr0;
    rd  = phase_ticks(CFG_RD_LOW) + phase_ticks(CFG_RD_SAMPLE) + READ_RECOVERY;
    rst = phase_ticks(CFG_RST_LOW) + phase_ticks(CFG_RST_REL);
    case (act)
      CMD_RESET:      return rst;
      CMD_WRITE_BIT:  return wr;
      CMD_READ_BIT:   return rd;
      CMD_WRITE_BYTE: return 8 * wr;
      CMD_READ_BYTE:  return 8 * rd;
      CMD_READ_ID:    return rst + 16 * wr + ID_BITS_DEFAULT * rd;
      default:        return 0;
    endcase
  endfunction

  function automatic logic line_for(input logic [1:0] mode);
    case (mode)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(1));
    endcase
  endfunction

  // hold valid across back-to-back transfers, drop it only for a gap
  task automatic send_item(input logic [2:0] act, input logic [7:0] data, input logic line);
    int unsigned gap;
    s_axis_tdata  <= {4'b0000, line, data, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_ticks(input int unsigned n, input logic [1:0] mode, input bit intrude);
    int unsigned r;
    logic [2:0]  act;
    logic [7:0]  data;
    repeat (n) begin
      r    = $urandom_range(63);
      data = 8'($urandom);
      act  = CMD_TICK;
      if (r == 1) act = ACT_SPARE;
      else if (intrude && r == 0) act = 3'($urandom_range(CMD_READ_ID, CMD_RESET));
      send_item(act, data, line_for(mode));
    end
  endtask

  task automatic run_cmd(input logic [2:0] act, input logic [7:0] data, input logic [1:0] mode,
                         input int unsigned n, input bit intrude);
    send_item(act, data, line_for(mode));
    cmds_sent++;
    run_ticks(n, mode, intrude);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // tick the master until its running command is over
  task automatic settle();
    drain();
    while (model_busy) begin
      send_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)));
      drain();
    end
  endtask

  task automatic load_timing(input cfg_t t);
    int unsigned i;
    settle();
    cfg_valid_i <= 1'b1;
    for (i = 0; i < CFG_REGS; i++) begin
      cfg_addr_i <= CFG_ADDR_W'(i);
      cfg_data_i <= t[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    timing = t;
    settings_used++;
  endtask

  task automatic random_set(input bit calm);
    cfg_t        t;
    int unsigned i, stop, r, n;
    logic [2:0]  act;
    for (i = 0; i < CFG_REGS; i++)
      t[i] = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(31, 16))
                                      : CFG_W'($urandom_range(15));
    load_timing(t);
    quiet = calm;
    stop = ticks_sent + RAND_TICKS / RAND_SETS;
    while (ticks_sent < stop) begin
      r = $urandom_range(9);
      if (r < 2) act = CMD_WRITE_BIT;
      else if (r < 4) act = CMD_READ_BIT;
      else if (r < 6) act = CMD_WRITE_BYTE;
      else if (r < 8) act = CMD_RESET;
      else act = CMD_READ_BYTE;
      n = cmd_len(act);
      // cut some commands short so the next one lands while busy
      if ($urandom_range(5) == 0) n = $urandom_range(n);
      run_cmd(act, 8'($urandom), LINE_RAND, n, 1'b1);
      if ($urandom_range(15) == 0) drain();
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (sink_stall != 0) begin
      sink_stall    <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      sink_gap       = pick_gap();
      m_axis_tready <= (sink_gap == 0);
      sink_stall    <= (sink_gap == 0) ? 0 : sink_gap - 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding", pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset timing: single slots, rejection while busy, spare action
    run_cmd(CMD_WRITE_BIT, 8'h01, LINE_RAND, cmd_len(CMD_WRITE_BIT), 1'b0);
    run_cmd(CMD_WRITE_BIT, 8'hFE, LINE_RAND, cmd_len(CMD_WRITE_BIT), 1'b0);
    run_cmd(CMD_READ_BIT, 8'h00, LINE_HIGH, cmd_len(CMD_READ_BIT), 1'b0);
    run_cmd(CMD_WRITE_BIT, 8'hFF, LINE_RAND, 3, 1'b0);
    send_item(CMD_READ_ID, 8'h00, 1'b1);
    send_item(CMD_RESET, 8'hFF, 1'b0);
    send_item(ACT_SPARE, 8'hFF, 1'b1);
    run_ticks(cmd_len(CMD_WRITE_BIT), LINE_RAND, 1'b0);
    send_item(ACT_SPARE, 8'h00, 1'b0);

    for (int unsigned s = 0; s < RAND_SETS; s++) random_set(s == 1);

    // zero in every register acts as one tick
    load_timing('0);
    run_cmd(CMD_WRITE_BYTE, 8'h5A, LINE_RAND, cmd_len(CMD_WRITE_BYTE), 1'b0);
    run_cmd(CMD_RESET, 8'hFF, LINE_RAND, cmd_len(CMD_RESET), 1'b0);
    run_cmd(CMD_READ_BIT, 8'h00, LINE_LOW, cmd_len(CMD_READ_BIT), 1'b0);

    // ROM id read left running at the end: reset, command byte and the first read slots
    run_cmd(CMD_READ_ID, 8'hC3, LINE_RAND, ID_HEAD_TICKS, 1'b1);

    drain();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d ticks and %0d commands under %0d timing settings; %0d results compared",
             ticks_sent, cmds_sent, settings_used, checked);
    $display("Covered reset, random and zero timing, busy rejections and a ROM id read start");
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
